[sv/srpd_pkg.sv]
// srpd_pkg: shared types and constants for the snapshot rle page decoder
// used by the front, command queue, back and top level; no dependencies
`timescale 1ns / 1ps

package srpd_pkg;

	localparam logic [7:0] ESC_BYTE = 8'hED;

	localparam logic [1:0] MODE_V1_RLE = 2'd0;
	localparam logic [1:0] MODE_V1_RAW = 2'd1;
	localparam logic [1:0] MODE_PAGED  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_PAGE  = 3'd1;
	localparam logic [2:0] ST_TRUNCATED = 3'd2;
	localparam logic [2:0] ST_CLIPPED   = 3'd3;
	localparam logic [2:0] ST_ENDED     = 3'd4;

	localparam logic [7:0] PAGE_8000 = 8'd4;
	localparam logic [7:0] PAGE_C000 = 8'd5;
	localparam logic [7:0] PAGE_4000 = 8'd8;

	localparam logic [16:0] PTR_RESET = 17'h04000;
	localparam logic [15:0] END_RESET = 16'h7FFF;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_input;
	} in_item_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_address;
		logic [7:0]  write_value;
		logic [7:0]  repeat_count;
		logic [2:0]  status_code;
		logic        last_result;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_PAIR,
		CMD_PAGE,
		CMD_STATUS
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] value;
		logic [7:0] count;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic       restart;
		logic [1:0] new_mode;
		logic [1:0] mode;
	} cfg_ctl_t;

endpackage

[sv/srpd_front.sv]
// srpd_front: parses the byte stream (escapes, block headers, end marks)
// and turns each byte into at most one command; depends on srpd_pkg
`timescale 1ns / 1ps

module srpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srpd_pkg::cfg_ctl_t   cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srpd_pkg::in_item_t   in_data,
	input  logic                 q_full,
	output logic                 push,
	output srpd_pkg::cmd_t       push_cmd
);

	typedef enum logic [2:0] {
		PH_PLAIN,
		PH_ESC,
		PH_ESC2,
		PH_VALUE,
		PH_LEN_LO,
		PH_LEN_HI,
		PH_PAGE
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [7:0]  run_q, run_n;
	logic [15:0] remain_q, remain_n;
	logic [7:0]  len_lo_q, len_lo_n;
	logic        halted_q, halted_n;
	logic        accept;
	logic [7:0]  b;
	logic        paged;
	logic        trunc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign b        = in_data.data_byte;
	assign paged    = (cfg.mode == srpd_pkg::MODE_PAGED);
	assign trunc    = (phase_q inside {PH_ESC, PH_ESC2, PH_VALUE, PH_LEN_HI, PH_PAGE});

	always_comb begin
		phase_n  = phase_q;
		run_n    = run_q;
		remain_n = remain_q;
		len_lo_n = len_lo_q;
		halted_n = halted_q;
		push     = 1'b0;
		push_cmd = '{kind: srpd_pkg::CMD_STATUS, value: b, count: 8'd1,
			status: srpd_pkg::ST_OK};
		if (!accept || halted_q || cfg.mode == srpd_pkg::MODE_UNUSED) begin
			phase_n = phase_q;
		end else if (in_data.end_of_input) begin
			push            = 1'b1;
			push_cmd.status = trunc ? srpd_pkg::ST_TRUNCATED : srpd_pkg::ST_ENDED;
			halted_n        = 1'b1;
		end else if (paged && phase_q == PH_LEN_LO) begin
			len_lo_n = b;
			phase_n  = PH_LEN_HI;
		end else if (paged && phase_q == PH_LEN_HI) begin
			remain_n = {b, len_lo_q};
			phase_n  = PH_PAGE;
		end else if (paged && phase_q == PH_PAGE) begin
			push = 1'b1;
			if (b == srpd_pkg::PAGE_8000 || b == srpd_pkg::PAGE_C000 ||
				b == srpd_pkg::PAGE_4000) begin
				push_cmd.kind = srpd_pkg::CMD_PAGE;
				phase_n       = (remain_q != 16'd0) ? PH_PLAIN : PH_LEN_LO;
			end else begin
				push_cmd.status = srpd_pkg::ST_BAD_PAGE;
				halted_n        = 1'b1;
			end
		end else begin
			if (paged && remain_q != 16'd0) begin
				remain_n = remain_q - 16'd1;
			end
			if (cfg.mode == srpd_pkg::MODE_V1_RAW) begin
				push          = 1'b1;
				push_cmd.kind = srpd_pkg::CMD_WRITE;
			end else begin
				case (phase_q)
					PH_PLAIN: begin
						if (b == srpd_pkg::ESC_BYTE) begin
							phase_n = PH_ESC;
						end else begin
							push          = 1'b1;
							push_cmd.kind = srpd_pkg::CMD_WRITE;
						end
					end
					PH_ESC: begin
						if (b == srpd_pkg::ESC_BYTE) begin
							phase_n = PH_ESC2;
						end else begin
							push          = 1'b1;
							push_cmd.kind = srpd_pkg::CMD_PAIR;
							phase_n       = PH_PLAIN;
						end
					end
					PH_ESC2: begin
						if (b == 8'd0) begin
							if (cfg.mode == srpd_pkg::MODE_V1_RLE) begin
								push            = 1'b1;
								push_cmd.status = srpd_pkg::ST_ENDED;
								halted_n        = 1'b1;
							end else begin
								phase_n = PH_LEN_LO;
							end
						end else begin
							run_n   = b;
							phase_n = PH_VALUE;
						end
					end
					default: begin
						push           = 1'b1;
						push_cmd.kind  = srpd_pkg::CMD_WRITE;
						push_cmd.count = run_q;
						phase_n        = PH_PLAIN;
					end
				endcase
			end
			if (paged && phase_n == PH_PLAIN && remain_n == 16'd0) begin
				phase_n = PH_LEN_LO;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PLAIN;
			run_q    <= 8'd0;
			remain_q <= 16'd0;
			len_lo_q <= 8'd0;
			halted_q <= 1'b0;
		end else if (cfg.restart) begin
			phase_q  <= (cfg.new_mode == srpd_pkg::MODE_PAGED) ? PH_LEN_LO : PH_PLAIN;
			run_q    <= 8'd0;
			remain_q <= 16'd0;
			len_lo_q <= 8'd0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			run_q    <= run_n;
			remain_q <= remain_n;
			len_lo_q <= len_lo_n;
			halted_q <= halted_n;
		end
	end

endmodule

[sv/srpd_cmdq.sv]
// srpd_cmdq: short command queue between front and back
// depends on srpd_pkg for the command type and depth
`timescale 1ns / 1ps

module srpd_cmdq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            flush,
	input  logic            push,
	input  srpd_pkg::cmd_t  push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            empty,
	output srpd_pkg::cmd_t  head
);

	srpd_pkg::cmd_t              mem [srpd_pkg::QDEPTH];
	logic [srpd_pkg::QAW-1:0]    wr_q;
	logic [srpd_pkg::QAW-1:0]    rd_q;
	logic [srpd_pkg::QAW:0]      count_q;

	assign full  = (count_q == (srpd_pkg::QAW+1)'(srpd_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else if (flush) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (srpd_pkg::QAW+1)'(srpd_pkg::QDEPTH)) else $error("queue count out of range");

endmodule

[sv/srpd_back.sv]
// srpd_back: executes queued commands, keeps the write pointer, clips runs
// at the region end and holds the output register; depends on srpd_pkg
`timescale 1ns / 1ps

module srpd_back #(
	parameter int IMAGE_BYTES = 49152
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  srpd_pkg::cfg_ctl_t   cfg,
	input  logic                 q_empty,
	input  srpd_pkg::cmd_t       head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output srpd_pkg::out_item_t  out_data
);

	localparam logic [16:0] V1_END = 17'(32'h4000 + IMAGE_BYTES - 1);

	logic [16:0]          ptr_q, ptr_n;
	logic [15:0]          pend_q, pend_n;
	logic                 second_q, second_n;
	logic                 out_valid_q;
	srpd_pkg::out_item_t  out_q, res;
	logic                 load;
	logic                 advance;
	logic [16:0]          region_end;
	logic [16:0]          diff;
	logic [17:0]          avail;
	logic [7:0]           wval;
	logic [7:0]           wcnt;
	logic [7:0]           clip_cnt;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign advance   = !out_valid_q || out_ready;

	assign region_end = (cfg.mode == srpd_pkg::MODE_PAGED) ? {1'b0, pend_q} : V1_END;
	assign diff       = region_end - ptr_q;
	assign avail      = (ptr_q <= region_end) ? ({1'b0, diff} + 18'd1) : 18'd0;
	assign wval       = (head.kind == srpd_pkg::CMD_PAIR && !second_q) ?
		srpd_pkg::ESC_BYTE : head.value;
	assign wcnt       = (head.kind == srpd_pkg::CMD_WRITE) ? head.count : 8'd1;
	assign clip_cnt   = ({10'd0, wcnt} < avail) ? wcnt : avail[7:0];

	always_comb begin
		pop      = 1'b0;
		load     = 1'b0;
		ptr_n    = ptr_q;
		pend_n   = pend_q;
		second_n = second_q;
		res      = '0;
		if (!q_empty && advance) begin
			case (head.kind)
				srpd_pkg::CMD_PAGE: begin
					pop = 1'b1;
					if (head.value == srpd_pkg::PAGE_8000) begin
						ptr_n  = 17'h08000;
						pend_n = 16'hBFFF;
					end else if (head.value == srpd_pkg::PAGE_C000) begin
						ptr_n  = 17'h0C000;
						pend_n = 16'hFFFF;
					end else begin
						ptr_n  = srpd_pkg::PTR_RESET;
						pend_n = srpd_pkg::END_RESET;
					end
				end
				srpd_pkg::CMD_STATUS: begin
					pop             = 1'b1;
					load            = 1'b1;
					res.status_code = head.status;
					res.last_result = 1'b1;
				end
				default: begin
					load              = 1'b1;
					res.write_valid   = (clip_cnt != 8'd0);
					res.write_address = ptr_q[15:0];
					res.write_value   = wval;
					res.repeat_count  = clip_cnt;
					res.status_code   = (clip_cnt < wcnt) ? srpd_pkg::ST_CLIPPED :
						srpd_pkg::ST_OK;
					ptr_n             = ptr_q + {9'd0, clip_cnt};
					if (head.kind == srpd_pkg::CMD_PAIR && !second_q) begin
						second_n = 1'b1;
					end else begin
						second_n        = 1'b0;
						pop             = 1'b1;
						res.last_result = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= srpd_pkg::PTR_RESET;
			pend_q      <= srpd_pkg::END_RESET;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (cfg.restart) begin
			ptr_q       <= srpd_pkg::PTR_RESET;
			pend_q      <= srpd_pkg::END_RESET;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			ptr_q    <= ptr_n;
			pend_q   <= pend_n;
			second_q <= second_n;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_status_only_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status_code == srpd_pkg::ST_BAD_PAGE ||
		out_q.status_code == srpd_pkg::ST_TRUNCATED ||
		out_q.status_code == srpd_pkg::ST_ENDED)
		|-> !out_q.write_valid && out_q.repeat_count == 8'd0)
		else $error("status-only result carries a write");
	a_write_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.write_valid |-> out_q.repeat_count != 8'd0)
		else $error("write with zero repeat count");
	a_pair_pending: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> !q_empty && head.kind == srpd_pkg::CMD_PAIR)
		else $error("second half of pair without pair command");
	a_pair_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && !second_q && head.kind == srpd_pkg::CMD_PAIR |=> !out_q.last_result)
		else $error("first half of pair marked last");

endmodule

[sv/snapshot_rle_page_decoder_core.sv]
// snapshot_rle_page_decoder_core: top level of the snapshot rle page decoder
// instantiates srpd_front, srpd_cmdq and srpd_back; depends on srpd_pkg
//
// usage: the memory stream after the snapshot header enters one byte per
// transfer on in_valid/in_ready/in_data; write descriptors leave on
// out_valid/out_ready/out_data, last_result marking the final one per byte.
// cfg_we with cfg_wdata sets format_mode and restarts the decoder; write it
// only while the block is idle.
// a byte's result reaches out_data through the command queue and the output register.
// throughput: one byte per cycle while the queue is not full; a literal escape
// pair gives the back end two results, every other command at most one, and a
// four-entry command queue absorbs the difference.
// reset: decoder in plain data phase, mode 0, pointer 0x4000, queue and
// output register empty.
// when out_ready is low the output register holds its result, the queue
// fills, and in_ready drops once the queue is full.
`timescale 1ns / 1ps

module snapshot_rle_page_decoder_core #(
	parameter int IMAGE_BYTES = 49152
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  srpd_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output srpd_pkg::out_item_t  out_data
);

	logic [1:0]          format_mode_q;
	srpd_pkg::cfg_ctl_t  cfg;
	logic                q_full;
	logic                q_empty;
	logic                push;
	logic                pop;
	srpd_pkg::cmd_t      push_cmd;
	srpd_pkg::cmd_t      head;

	assign cfg.restart  = cfg_we;
	assign cfg.new_mode = cfg_wdata;
	assign cfg.mode     = format_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= srpd_pkg::MODE_V1_RLE;
		end else if (cfg_we) begin
			format_mode_q <= cfg_wdata;
		end
	end

	srpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	srpd_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flush    (cfg_we),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (q_full),
		.empty    (q_empty),
		.head     (head)
	);

	srpd_back #(
		.IMAGE_BYTES (IMAGE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
